// ===== rtl/lst_pkg.sv =====
// lst_pkg: shared types and constants for the login session table
// no dependencies; imported by lst_cell, lst_ctrl and login_session_table
package lst_pkg;

	localparam int HANDLE_W = 32;
	localparam int ROLE_W   = 2;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int PLEN_W   = 8;
	localparam int ITER_W   = 32;
	localparam int CFG_IDX_W = 1;

	// opcodes
	localparam logic [OP_W-1:0] OP_LOGIN      = 3'd0;
	localparam logic [OP_W-1:0] OP_CHECK_ROLE = 3'd1;
	localparam logic [OP_W-1:0] OP_LOGOUT     = 3'd2;
	localparam logic [OP_W-1:0] OP_LOGOUT_ALL = 3'd3;
	localparam logic [OP_W-1:0] OP_PIN_CHECK  = 3'd4;
	localparam logic [OP_W-1:0] OP_SET_ITER   = 3'd5;

	// roles
	localparam logic [ROLE_W-1:0] ROLE_NONE    = 2'd0;
	localparam logic [ROLE_W-1:0] ROLE_USER    = 2'd1;
	localparam logic [ROLE_W-1:0] ROLE_OFFICER = 2'd2;
	localparam logic [ROLE_W-1:0] ROLE_WHEEL   = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_IMPOSSIBLE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FORBIDDEN  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 2'd3;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PIN = 1'd1;
	localparam logic [PLEN_W-1:0]    MIN_PIN_RESET = 8'd4;
	localparam logic [PLEN_W-1:0]    MAX_PIN_RESET = 8'd64;

	localparam logic [ITER_W-1:0] DEFAULT_ITER = 32'd2000;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [ROLE_W-1:0]   role;
	} entry_t;

endpackage

// ===== rtl/login_session_table.sv =====
// login_session_table: top level; ring of lst_cell entries driven by lst_ctrl
// depends on lst_pkg, lst_cell, lst_ctrl
//
// Session table of NUM_SLOTS entries kept in a ring of cells that rotates by
// one entry a cycle while a request is processed; the sequencer sees entries in
// index order at the head and writes them back at the tail. Every request takes
// one full rotation (S_SCAN) and then posts its result from S_DONE, so a new
// request is accepted only after the previous one has posted its result.
// Record login needs a second rotation to place the entry.
// Logout all emits one result per occupied entry and the rotation pauses while
// the response register is held by a stalled consumer. The user writes the pin
// length limits through the cfg port only while idle; the block does not enforce it.
module login_session_table
	import lst_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PLEN_W-1:0]    cfg_data,
	// requests
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [OP_W-1:0]      opcode,
	input  logic [HANDLE_W-1:0]  client_id,
	input  logic [ROLE_W-1:0]    role,
	input  logic [PLEN_W-1:0]    pin_length,
	input  logic [ITER_W-1:0]    iteration_count,
	// results
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [HANDLE_W-1:0]  released_handle,
	output logic                 release_valid,
	output logic [ITER_W-1:0]    current_iterations,
	output logic                 last
);

	logic [PLEN_W-1:0] min_pin_q;
	logic [PLEN_W-1:0] max_pin_q;

	entry_t cell_q [NUM_SLOTS];
	entry_t tail;
	logic   shift;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pin_q <= MIN_PIN_RESET;
			max_pin_q <= MAX_PIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_PIN: min_pin_q <= cfg_data;
				CFG_MAX_PIN: max_pin_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// cell k takes its neighbor's entry; the last cell takes the tail
	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
		entry_t d;
		if (k == NUM_SLOTS - 1) begin : g_end
			assign d = tail;
		end else begin : g_mid
			assign d = cell_q[k+1];
		end
		lst_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (cell_q[k])
		);
	end

	lst_ctrl #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.req_valid          (req_valid),
		.req_stall          (req_stall),
		.opcode             (opcode),
		.client_id          (client_id),
		.role               (role),
		.pin_length         (pin_length),
		.iteration_count    (iteration_count),
		.min_pin            (min_pin_q),
		.max_pin            (max_pin_q),
		.head               (cell_q[0]),
		.tail               (tail),
		.shift              (shift),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.status             (status),
		.released_handle    (released_handle),
		.release_valid      (release_valid),
		.current_iterations (current_iterations),
		.last               (last)
	);

endmodule

// ===== rtl/lst_cell.sv =====
// lst_cell: one session entry of the rotating table
// depends on lst_pkg (entry_t)
module lst_cell
	import lst_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  entry_t d,
	output entry_t q
);

	entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

// ===== rtl/lst_ctrl.sv =====
// lst_ctrl: request sequencer that walks the cell ring and builds results
// depends on lst_pkg; sees the ring through its head and tail entries
module lst_ctrl
	import lst_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [OP_W-1:0]     opcode,
	input  logic [HANDLE_W-1:0] client_id,
	input  logic [ROLE_W-1:0]   role,
	input  logic [PLEN_W-1:0]   pin_length,
	input  logic [ITER_W-1:0]   iteration_count,
	// pin limits
	input  logic [PLEN_W-1:0]   min_pin,
	input  logic [PLEN_W-1:0]   max_pin,
	// ring access
	input  entry_t              head,
	output entry_t              tail,
	output logic                shift,
	// response channel
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [STATUS_W-1:0] status,
	output logic [HANDLE_W-1:0] released_handle,
	output logic                release_valid,
	output logic [ITER_W-1:0]   current_iterations,
	output logic                last
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_COMMIT = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] step_q;

	// latched request
	logic [OP_W-1:0]     op_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [ROLE_W-1:0]   role_q;
	logic [PLEN_W-1:0]   plen_q;
	logic [ITER_W-1:0]   iter_q;

	// scan findings
	logic                found_q;
	logic [IDX_W-1:0]    found_idx_q;
	logic [ROLE_W-1:0]   found_role_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                pend_valid_q;
	logic [HANDLE_W-1:0] pend_handle_q;

	logic [ITER_W-1:0]   iters_q;

	// response register
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [HANDLE_W-1:0] rel_handle_q;
	logic                rel_valid_q;
	logic [ITER_W-1:0]   cur_iters_q;
	logic                last_q;

	logic                accept;
	logic                occ;
	logic                hit;
	logic                last_step;
	logic                out_free;
	logic                emit_mid;
	logic                done_load;
	logic                have_tgt;
	logic [IDX_W-1:0]    tgt_idx;
	logic [IDX_W-1:0]    step_next;
	logic                pin_len_bad;
	logic                is_wheel;
	logic                is_officer;
	logic                iter_ok;
	logic [ITER_W-1:0]   new_iters;
	logic [STATUS_W-1:0] res_status;
	logic [HANDLE_W-1:0] res_handle;
	logic                res_rel_valid;
	logic [ITER_W-1:0]   res_iters;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign occ       = (head.role != ROLE_NONE);
	assign hit       = occ && (head.handle == handle_q);
	assign last_step = (step_q == LAST_IDX);
	assign step_next = last_step ? '0 : step_q + 1'b1;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign have_tgt  = found_q || free_found_q;
	assign tgt_idx   = found_q ? found_idx_q : free_idx_q;

	// ring traversal: head leaves, tail re-enters possibly modified
	always_comb begin
		tail     = head;
		shift    = 1'b0;
		emit_mid = 1'b0;
		unique case (state_q)
			S_SCAN: begin
				shift = 1'b1;
				if (op_q == OP_LOGOUT_ALL && occ) begin
					tail = '0;
					// the held handle goes out now, it is known not to be the last
					if (pend_valid_q) begin
						if (out_free) begin
							emit_mid = 1'b1;
						end else begin
							shift = 1'b0;
						end
					end
				end
				if (op_q == OP_LOGOUT && hit && !found_q) begin
					tail = '0;
				end
			end
			S_COMMIT: begin
				shift = 1'b1;
				if (have_tgt && step_q == tgt_idx) begin
					tail.handle = handle_q;
					tail.role   = role_q;
				end
			end
			S_IDLE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// final result of a request
	always_comb begin
		pin_len_bad   = (plen_q < min_pin) || (plen_q > max_pin);
		is_wheel      = found_q && (found_role_q == ROLE_WHEEL);
		is_officer    = found_q && (found_role_q == ROLE_OFFICER);
		iter_ok       = is_wheel || is_officer;
		new_iters     = (iter_q == '0) ? DEFAULT_ITER : iter_q;
		res_status    = ST_IMPOSSIBLE;
		res_handle    = '0;
		res_rel_valid = 1'b0;
		res_iters     = iters_q;
		unique case (op_q)
			OP_LOGIN: begin
				if (role_q == ROLE_NONE) begin
					res_status = ST_IMPOSSIBLE;
				end else begin
					res_status = have_tgt ? ST_OK : ST_NO_SLOT;
				end
			end
			OP_CHECK_ROLE: begin
				if (role_q == ROLE_NONE) begin
					res_status = ST_IMPOSSIBLE;
				end else begin
					res_status = (found_q && found_role_q == role_q) ? ST_OK : ST_FORBIDDEN;
				end
			end
			OP_LOGOUT: begin
				res_status    = ST_OK;
				res_handle    = found_q ? handle_q : '0;
				res_rel_valid = found_q;
			end
			OP_LOGOUT_ALL: begin
				res_status    = ST_OK;
				res_handle    = pend_valid_q ? pend_handle_q : '0;
				res_rel_valid = pend_valid_q;
			end
			OP_PIN_CHECK: begin
				if (pin_len_bad) begin
					res_status = ST_IMPOSSIBLE;
				end else if (is_wheel || (role_q == ROLE_USER && is_officer)) begin
					res_status = ST_OK;
				end else begin
					res_status = ST_FORBIDDEN;
				end
			end
			OP_SET_ITER: begin
				res_status = iter_ok ? ST_OK : ST_FORBIDDEN;
				res_iters  = iter_ok ? new_iters : iters_q;
			end
			default: begin
				res_status = ST_IMPOSSIBLE;
			end
		endcase
	end

	assign done_load = (state_q == S_DONE) && out_free;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			pend_valid_q <= 1'b0;
			iters_q      <= DEFAULT_ITER;
			rsp_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q      <= S_SCAN;
						step_q       <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						pend_valid_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (shift) begin
						step_q <= step_next;
						if (hit && !found_q) begin
							found_q <= 1'b1;
						end
						if (!occ && !free_found_q) begin
							free_found_q <= 1'b1;
						end
						if (op_q == OP_LOGOUT_ALL && occ) begin
							pend_valid_q <= 1'b1;
						end
						if (last_step) begin
							state_q <= (op_q == OP_LOGIN && role_q != ROLE_NONE) ?
								S_COMMIT : S_DONE;
						end
					end
				end
				S_COMMIT: begin
					step_q <= step_next;
					if (last_step) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						iters_q <= res_iters;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (emit_mid || done_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode;
			handle_q <= client_id;
			role_q   <= role;
			plen_q   <= pin_length;
			iter_q   <= iteration_count;
		end
		if (state_q == S_SCAN && shift) begin
			if (hit && !found_q) begin
				found_idx_q  <= step_q;
				found_role_q <= head.role;
			end
			if (!occ && !free_found_q) begin
				free_idx_q <= step_q;
			end
			if (op_q == OP_LOGOUT_ALL && occ) begin
				pend_handle_q <= head.handle;
			end
		end
		if (emit_mid) begin
			status_q     <= ST_OK;
			rel_handle_q <= pend_handle_q;
			rel_valid_q  <= 1'b1;
			cur_iters_q  <= iters_q;
			last_q       <= 1'b0;
		end else if (done_load) begin
			status_q     <= res_status;
			rel_handle_q <= res_handle;
			rel_valid_q  <= res_rel_valid;
			cur_iters_q  <= res_iters;
			last_q       <= 1'b1;
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign status             = status_q;
	assign released_handle    = rel_handle_q;
	assign release_valid      = rel_valid_q;
	assign current_iterations = cur_iters_q;
	assign last               = last_q;

	// the ring only moves while a pass is running
	a_shift_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		shift |-> (state_q == S_SCAN || state_q == S_COMMIT))
		else $error("ring moved outside a pass");

	// a result is never loaded over one that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_mid || done_load) |-> !(rsp_valid_q && rsp_stall))
		else $error("response register overwritten while stalled");

	// an accepted request always starts a scan pass
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SCAN && step_q == '0))
		else $error("accepted request did not start a scan");

	// a full rotation ends with the step counter back at the first entry
	a_pass_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(shift && last_step) |=> (step_q == '0))
		else $error("pass did not wrap the step counter");

	// intermediate logout-all results are never flagged as final
	a_mid_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit_mid |=> (rsp_valid && !last && release_valid))
		else $error("intermediate logout-all result malformed");

endmodule
